>>> hdl/gsr_pkg.sv
// ----------------------------------------------------------------------------
// gsr_pkg - GGA sentence receiver shared types and constants
// Payload structs for the request and response channels, parser states and
// the header character table.
// ----------------------------------------------------------------------------
`default_nettype none

package gsr_pkg;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_G      = 8'h47;
   localparam logic [7:0] CHAR_P      = 8'h50;
   localparam logic [7:0] CHAR_A      = 8'h41;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;

   // comma count at which the GPS quality field is open
   localparam logic [7:0] QUALITY_FIELD = 8'd5;

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic       store_valid;
      logic [7:0] store_index;
      logic [7:0] store_byte;
      logic       frame_done;
      logic [7:0] fix_quality;
      logic [8:0] stored_length;
      logic       overflow;
   } rsp_payload_type;

   typedef enum logic [7:0] {
      ST_DOLLAR  = 8'b0000_0001,
      ST_G1      = 8'b0000_0010,
      ST_P       = 8'b0000_0100,
      ST_G2      = 8'b0000_1000,
      ST_G3      = 8'b0001_0000,
      ST_A       = 8'b0010_0000,
      ST_COMMA   = 8'b0100_0000,
      ST_PAYLOAD = 8'b1000_0000
   } parse_state_type;

   // character expected in each header state
   function automatic logic [7:0] header_char(input parse_state_type st);
      logic [7:0] c;
      case (st)
         ST_DOLLAR: c = CHAR_DOLLAR;
         ST_G1:     c = CHAR_G;
         ST_P:      c = CHAR_P;
         ST_G2:     c = CHAR_G;
         ST_G3:     c = CHAR_G;
         ST_A:      c = CHAR_A;
         ST_COMMA:  c = CHAR_COMMA;
         default:   c = CHAR_DOLLAR;
      endcase
      return c;
   endfunction

   function automatic parse_state_type header_next(input parse_state_type st);
      parse_state_type n;
      case (st)
         ST_DOLLAR: n = ST_G1;
         ST_G1:     n = ST_P;
         ST_P:      n = ST_G2;
         ST_G2:     n = ST_G3;
         ST_G3:     n = ST_A;
         ST_A:      n = ST_COMMA;
         ST_COMMA:  n = ST_PAYLOAD;
         default:   n = ST_DOLLAR;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

>>> hdl/gsr_stream_ifs.sv
// ----------------------------------------------------------------------------
// gsr_stream_ifs - valid/ready channels of the GGA sentence receiver
// Request channel carries one received byte, response channel one result.
// ----------------------------------------------------------------------------
`default_nettype none

interface gsr_req_if;
   import gsr_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface gsr_rsp_if;
   import gsr_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/gga_sentence_receiver_core.sv
// ----------------------------------------------------------------------------
// gga_sentence_receiver_core - NMEA GGA sentence receiver
// Header match, payload store indexing, comma counting and fix capture.
// ----------------------------------------------------------------------------
// One received byte per request, one result per request. A byte is taken on
// any cycle the result register is empty or being drained, so the block runs
// at one byte per clock; the result follows in the next cycle. Spaces
// are ignored. The header "$GPGGA," is matched one character at a time; any
// mismatch drops back to hunting for '$' and clears the length and comma
// count. After the header every byte is reported as a buffer store at the
// running length, commas are counted, and non-comma bytes while five commas
// have passed become the fix quality. '*' pulses frame_done and rearms the
// header hunt but keeps the length. Filling slot BUF_LEN-1 raises overflow and
// clears parser, length and comma count. The buffer itself lives outside.
// ----------------------------------------------------------------------------
`default_nettype none

module gga_sentence_receiver_core #(
   parameter int BUF_LEN = 256
) (
   input  wire      clock,
   input  wire      reset,
   gsr_req_if.sink   req_chan,
   gsr_rsp_if.source rsp_chan
);
   import gsr_pkg::*;

   localparam int LEN_W = $clog2(BUF_LEN);
   localparam int EXT_W = (LEN_W > 9) ? LEN_W : 9;
   localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(BUF_LEN - 1);

   // parser state
   parse_state_type  state_ff, state_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [7:0]       comma_ff, comma_in;
   logic [7:0]       quality_ff, quality_in;

   // result register
   rsp_payload_type  rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             accept;
   logic [7:0]       rx;
   logic [EXT_W-1:0] len_old_ext, len_new_ext;

   // skid-free output register: take a byte when the slot is free or draining
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign rx             = req_chan.data.rx_byte;

   assign len_old_ext = EXT_W'(len_ff);
   assign len_new_ext = EXT_W'(len_in);

   always_comb begin
      state_in   = state_ff;
      len_in     = len_ff;
      comma_in   = comma_ff;
      quality_in = quality_ff;
      rsp_in     = '0;

      if (accept && (rx != CHAR_SPACE)) begin
         if (state_ff != ST_PAYLOAD) begin
            if (rx == header_char(state_ff)) begin
               state_in = header_next(state_ff);
            end else begin
               state_in = ST_DOLLAR;
               len_in   = '0;
               comma_in = '0;
            end
         end else begin
            rsp_in.store_valid = 1'b1;
            rsp_in.store_index = len_old_ext[7:0];
            rsp_in.store_byte  = rx;
            len_in             = len_ff + LEN_W'(1);
            if (rx == CHAR_COMMA) begin
               comma_in = comma_ff + 8'd1;
            end else if (comma_ff == QUALITY_FIELD) begin
               quality_in = rx;
            end
            if (rx == CHAR_STAR) begin
               rsp_in.frame_done = 1'b1;
               state_in          = ST_DOLLAR;
               comma_in          = '0;
            end
            // last slot written: buffer full, start over
            if (len_ff == LEN_LAST) begin
               rsp_in.overflow = 1'b1;
               state_in        = ST_DOLLAR;
               len_in          = '0;
               comma_in        = '0;
            end
         end
      end

      rsp_in.fix_quality   = quality_in;
      rsp_in.stored_length = len_new_ext[8:0];

      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_DOLLAR;
         len_ff       <= '0;
         comma_ff     <= '0;
         quality_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         comma_ff     <= comma_in;
         quality_ff   <= quality_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload only loads with a new request
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   // overflow only ever comes from a store
   a_ovf_is_store: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.overflow) |-> rsp_ff.store_valid)
      else $error("overflow reported without a store");

   // frame end is always the stored '*'
   a_done_is_star: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.frame_done) |->
         (rsp_ff.store_valid && (rsp_ff.store_byte == CHAR_STAR)))
      else $error("frame_done without a stored star");

   // a space leaves the parser untouched
   a_space_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && (rx == CHAR_SPACE)) |=>
         ($stable(state_ff) && $stable(len_ff) && $stable(comma_ff)))
      else $error("space byte changed parser state");

   // length never survives reaching the buffer size
   a_len_wraps: assert property (@(posedge clock) disable iff (reset)
      (accept && (state_ff == ST_PAYLOAD) && (rx != CHAR_SPACE)
         && (len_ff == LEN_LAST)) |=> (len_ff == '0))
      else $error("length not cleared after buffer full");

endmodule

`default_nettype wire

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb - self-checking testbench for gga_sentence_receiver_core
// Feeds received bytes over the request channel and checks every response
// against a cycle-free predictor of the header matcher, payload indexing,
// comma counting, fix capture and overflow. A short directed table comes
// first, then random sentences, broken headers, noise and one long frame.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gsr_pkg::*;

   localparam int BUF_LEN = 256;
   // rough total of requests, directed table included
   localparam int ITEMS = 700;
   localparam int DIRECTED_ROWS = 25;
   // header position 7 means the header is complete and bytes are stored
   localparam logic [2:0] POS_PAYLOAD = 3'd7;
   localparam logic [55:0] HEADER_STR = {CHAR_DOLLAR, CHAR_G, CHAR_P, CHAR_G,
                                         CHAR_G, CHAR_A, CHAR_COMMA};
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_SEVEN = 8'h37;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;

   typedef struct packed {
      logic [7:0]      rx;
      bit              typed;   // rsp below is the literal expectation
      rsp_payload_type rsp;
   } stim_row_type;

   logic clock;
   logic reset;

   gsr_req_if req_if ();
   gsr_rsp_if rsp_if ();

   gga_sentence_receiver_core #(
      .BUF_LEN (BUF_LEN)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Predictor state: header position, stored length, commas seen in the
   // current frame and the last captured quality character.
   logic [2:0] pred_pos;
   logic [8:0] pred_length;
   logic [7:0] pred_commas;
   logic [7:0] pred_quality;

   rsp_payload_type awaited_rsps[$];
   int mismatch_count;
   int items_sent;
   int src_idle_pct;
   int sink_stall_pct;
   bit long_frame_sent;

   // Directed table. Rows up to the first header expect an all-zero response
   // (nothing stored, no fix yet, length 0); the rest go through the predictor.
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{CHAR_SPACE,  1'b1, '0},   // space right after reset
      '{8'hFF,       1'b1, '0},   // all ones while hunting for '$'
      '{8'h00,       1'b1, '0},   // all zeros while hunting for '$'
      '{CHAR_DOLLAR, 1'b1, '0},
      '{CHAR_G,      1'b1, '0},
      '{CHAR_P,      1'b1, '0},
      '{CHAR_G,      1'b1, '0},
      '{CHAR_G,      1'b1, '0},
      '{CHAR_A,      1'b1, '0},
      '{CHAR_COMMA,  1'b1, '0},
      '{CHAR_COMMA,  1'b0, '0},   // five empty fields up to the quality field
      '{CHAR_COMMA,  1'b0, '0},
      '{CHAR_COMMA,  1'b0, '0},
      '{CHAR_COMMA,  1'b0, '0},
      '{CHAR_COMMA,  1'b0, '0},
      '{CHAR_SEVEN,  1'b0, '0},   // fix quality captured
      '{CHAR_STAR,   1'b0, '0},   // '*' inside the quality field overrides it
      '{CHAR_DOLLAR, 1'b0, '0},   // second header, length kept from last frame
      '{CHAR_G,      1'b0, '0},
      '{CHAR_P,      1'b0, '0},
      '{CHAR_G,      1'b0, '0},
      '{CHAR_G,      1'b0, '0},
      '{CHAR_A,      1'b0, '0},
      '{CHAR_COMMA,  1'b0, '0},
      '{8'h80,       1'b0, '0}    // stored at the kept length
   };

   // -------------------------------------------------------------------------
   // Predictor: advance the parser by one byte, return the response it causes
   // -------------------------------------------------------------------------
   function automatic rsp_payload_type parse_byte(input logic [7:0] b);
      rsp_payload_type r;
      r = '0;
      if (b != CHAR_SPACE) begin
         if (pred_pos != POS_PAYLOAD) begin
            // header hunt: a miss restarts without looking at the byte again
            if (b == HEADER_STR[55 - 8 * pred_pos -: 8]) begin
               pred_pos = pred_pos + 3'd1;
            end else begin
               pred_pos = '0;
               pred_length = '0;
               pred_commas = '0;
            end
         end else begin
            r.store_valid = 1'b1;
            r.store_index = pred_length[7:0];
            r.store_byte = b;
            pred_length = pred_length + 9'd1;
            if (b == CHAR_COMMA) begin
               pred_commas = pred_commas + 8'd1;
            end else if (pred_commas == QUALITY_FIELD) begin
               pred_quality = b;
            end
            // end of frame keeps the length for the next sentence
            if (b == CHAR_STAR) begin
               r.frame_done = 1'b1;
               pred_pos = '0;
               pred_commas = '0;
            end
            // last slot written: parser starts over, may coincide with '*'
            if (pred_length >= BUF_LEN) begin
               r.overflow = 1'b1;
               pred_pos = '0;
               pred_length = '0;
               pred_commas = '0;
            end
         end
      end
      r.fix_quality = pred_quality;
      r.stored_length = pred_length;
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Clock, run limit
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // generous bound: ~750 requests with 82% idling on either side
   initial begin
      #2ms;
      $display("tb: FAIL");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------
   // One request: random idle cycles, then hold valid until accepted. The
   // expectation is queued at the accepting edge, before the earliest
   // response can show up.
   task automatic send_byte(input logic [7:0] b, input bit typed,
                            input rsp_payload_type typed_rsp);
      rsp_payload_type predicted;
      while ($urandom_range(99) < src_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data.rx_byte <= b;
      do @(posedge clock); while (!req_if.ready);
      predicted = parse_byte(b);
      awaited_rsps.push_back(typed ? typed_rsp : predicted);
      items_sent++;
   endtask

   // random byte through the predictor, now and then preceded by a space
   task automatic send_noisy(input logic [7:0] b);
      if ($urandom_range(99) < 4) begin
         send_byte(CHAR_SPACE, 1'b0, '0);
      end
      send_byte(b, 1'b0, '0);
   endtask

   // first n characters of "$GPGGA,"
   task automatic send_header(input int n);
      for (int k = 0; k < n; k++) begin
         send_noisy(HEADER_STR[55 - 8 * k -: 8]);
      end
   endtask

   // mostly digits and NMEA letters, sometimes any byte at all
   function automatic logic [7:0] payload_char(input bit allow_star);
      logic [7:0] c;
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) begin
         c = CHAR_ZERO + 8'($urandom_range(9));
      end else if (pick < 80) begin
         case ($urandom_range(4))
            0:       c = 8'h2E;   // '.'
            1:       c = 8'h4E;   // 'N'
            2:       c = 8'h45;   // 'E'
            3:       c = 8'h57;   // 'W'
            default: c = 8'h4D;   // 'M'
         endcase
      end else begin
         c = 8'($urandom_range(255));
      end
      if (!allow_star && c == CHAR_STAR) begin
         c = CHAR_ZERO;
      end
      return c;
   endfunction

   function automatic logic [7:0] hex_char();
      logic [7:0] v;
      v = 8'($urandom_range(15));
      return (v < 8'd10) ? CHAR_ZERO + v : CHAR_UPPER_A + v - 8'd10;
   endfunction

   task automatic send_sentence();
      int pick;
      int nfields;
      int flen;
      pick = $urandom_range(99);
      if (!long_frame_sent && items_sent >= ITEMS / 2) begin
         // one frame past the buffer end, no '*' to stop it
         long_frame_sent = 1'b1;
         send_header(7);
         repeat (BUF_LEN + 10) send_noisy(payload_char(1'b0));
      end else if (pick < 60) begin
         // well-formed GGA; without a checksum the length keeps growing
         // into the next frame, so back-to-back frames reach overflow too
         send_header(7);
         nfields = $urandom_range(14, 4);
         for (int f = 0; f < nfields; f++) begin
            flen = $urandom_range(4);
            for (int k = 0; k < flen; k++) begin
               if (f == 5) begin
                  send_noisy(CHAR_ZERO + 8'($urandom_range(8)));
               end else begin
                  send_noisy(payload_char(1'b1));
               end
            end
            if (f != nfields - 1) begin
               send_noisy(CHAR_COMMA);
            end
         end
         send_noisy(CHAR_STAR);
         if ($urandom_range(1) == 1) begin
            send_noisy(hex_char());
            send_noisy(hex_char());
         end
      end else if (pick < 75) begin
         // header cut short by an arbitrary byte
         send_header($urandom_range(6));
         send_noisy(8'($urandom_range(255)));
      end else if (pick < 90) begin
         repeat ($urandom_range(8, 1)) send_noisy(8'($urandom_range(255)));
      end else begin
         // frame ending right in the quality field
         send_header(7);
         repeat (5) send_noisy(CHAR_COMMA);
         if ($urandom_range(1) == 1) begin
            send_noisy(CHAR_ZERO + 8'($urandom_range(8)));
         end
         send_noisy(CHAR_STAR);
      end
   endtask

   // hold off new requests until every response is back
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (awaited_rsps.size() != 0);
   endtask

   initial begin
      int phase;
      phase = 0;
      pred_pos = '0;
      pred_length = '0;
      pred_commas = '0;
      pred_quality = '0;
      mismatch_count = 0;
      items_sent = 0;
      long_frame_sent = 1'b0;
      src_idle_pct = 15;
      sink_stall_pct = 82;
      req_if.valid <= 1'b0;
      req_if.data <= '0;
      reset <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].rsp);
      end

      // three idling regimes, the second and third entered with the pipe empty
      while (items_sent < ITEMS) begin
         if (phase == 0 && items_sent >= ITEMS / 3) begin
            phase = 1;
            wait_drained();
            src_idle_pct = 82;
            sink_stall_pct = 15;
         end else if (phase == 1 && items_sent >= 2 * ITEMS / 3) begin
            phase = 2;
            wait_drained();
            src_idle_pct = 0;
            sink_stall_pct = 0;
         end
         send_sentence();
      end

      req_if.valid <= 1'b0;
      do @(posedge clock); while (awaited_rsps.size() != 0);
      // keep watching so that any stray response is caught
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   // -------------------------------------------------------------------------
   // Response side: random stalls, check every accepted response in order
   // -------------------------------------------------------------------------
   task automatic check_field(input string name, input logic [8:0] want,
                              input logic [8:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_rsp(input rsp_payload_type got);
      rsp_payload_type want;
      if (awaited_rsps.size() == 0) begin
         $display("%0t: response with none expected, expected none, actual %h",
                  $time, got);
         mismatch_count++;
      end else begin
         want = awaited_rsps.pop_front();
         check_field("store_valid", 9'(want.store_valid), 9'(got.store_valid));
         check_field("store_index", 9'(want.store_index), 9'(got.store_index));
         check_field("store_byte", 9'(want.store_byte), 9'(got.store_byte));
         check_field("frame_done", 9'(want.frame_done), 9'(got.frame_done));
         check_field("fix_quality", 9'(want.fix_quality), 9'(got.fix_quality));
         check_field("stored_length", want.stored_length, got.stored_length);
         check_field("overflow", 9'(want.overflow), 9'(got.overflow));
      end
   endtask

   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            check_rsp(rsp_if.data);
         end
         rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

endmodule
